### hdl/mma_pkg.sv
`timescale 1ns / 1ps

package mma_pkg;

  localparam int CHANNELS      = 8;
  localparam int WINDOW_MAX    = 64;
  localparam int SAMPLE_BITS   = 32;

  localparam int CH_BITS       = 3;
  localparam int PTR_BITS      = $clog2(WINDOW_MAX);
  localparam int LEN_BITS      = 7;
  localparam int ADDR_BITS     = CH_BITS + PTR_BITS;
  localparam int DEPTH         = CHANNELS * WINDOW_MAX;
  localparam int SUM_BITS      = SAMPLE_BITS + PTR_BITS;
  localparam int CNT_BITS      = $clog2(SUM_BITS);
  localparam int TDATA_BITS    = ((CH_BITS + SAMPLE_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 8;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WINDOW_LENGTH  = 1'b0,
    REG_CHANNEL_ENABLE = 1'b1
  } cfg_reg_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic rd_issue;
    logic update;
    logic prep;
    logic div_step;
    logic out_load;
  } mma_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic avg_en;
    logic div_last;
    logic out_free;
  } mma_status_t;

endpackage

### hdl/multichannel_moving_average_top.sv
`timescale 1ns / 1ps
// Multichannel moving average.
// Input items arrive on the s_ side: a channel index, a gauge flag and a signed
// Q16.16 sample. For an enabled channel and a gauge sample, the sample replaces
// the oldest entry of that channel's window and the result is the window sum
// divided by the window length, truncated toward zero. Any other item passes
// its sample through with the averaged flag clear. Exactly one result item per
// input item leaves on the m_ side, in order.
// An averaged item runs through capture, window read, update, divider load,
// 38 restoring divider steps that retire one quotient bit each, and hand off;
// a pass-through item goes from capture to hand off without those steps.
// One item is in work at a time; the next is accepted in the cycle after the
// current result has moved into the output register, and a result may wait
// there while the next item is in work.
// Reset clears all windows, pointers and sums, sets the window length to 1 and
// enables all channels. Writing the window length clears the windows again at
// once. Configure only while idle.
// When the receiver stalls, the result holds in the output register and the
// block stops taking items once its next result is ready.

module multichannel_moving_average_top
  import mma_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration write port
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  // Input items
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [TDATA_BITS-1:0]    s_tdata,   // channel[2:0], sample[34:3], zero pad
  input  logic [0:0]               s_tuser,   // is_gauge[0]
  // Result items
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [TDATA_BITS-1:0]    m_tdata,   // out_channel[2:0], value[34:3], zero pad
  output logic [0:0]               m_tuser    // averaged[0]
);

  mma_cmd_t    cmd;
  mma_status_t status;

  // Sequence each item: capture, then read window, update, divide when averaging, then hand off
  mma_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .status_i(status),
    .cmd_o   (cmd)
  );

  // Hold config, per-channel sums and pointers, window memory and divider
  mma_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

### hdl/mma_ram.sv
`timescale 1ns / 1ps

module mma_ram #(
  parameter int Width    = 32,
  parameter int Depth    = 512,
  parameter int AddrBits = $clog2(Depth)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/mma_ctrl.sv
`timescale 1ns / 1ps

module mma_ctrl
  import mma_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  mma_status_t status_i,
  output mma_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_UPDATE = 6'b000100,
    S_PREP   = 6'b001000,
    S_DIVIDE = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_READ;
        end
      end
      S_READ: begin
        if (status_i.avg_en) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_UPDATE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_tready = (state_q == S_IDLE);

endmodule

### hdl/mma_datapath.sv
`timescale 1ns / 1ps

module mma_datapath
  import mma_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic [TDATA_BITS-1:0]    s_tdata,
  input  logic [0:0]               s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [TDATA_BITS-1:0]    m_tdata,
  output logic [0:0]               m_tuser,
  input  mma_cmd_t                 cmd_i,
  output mma_status_t              status_o
);

  // Configuration
  logic [LEN_BITS-1:0]  wl_q;
  logic [CHANNELS-1:0]  en_q;
  logic [LEN_BITS-1:0]  len;

  // Captured input item
  logic [CH_BITS-1:0]            in_ch_q;
  logic                          in_gauge_q;
  logic signed [SAMPLE_BITS-1:0] in_sample_q;

  // Per-channel state
  logic [PTR_BITS-1:0]        ptr_q  [CHANNELS];
  logic signed [SUM_BITS-1:0] sum_q  [CHANNELS];
  logic [CHANNELS-1:0]        full_q;

  // Divider
  logic [SUM_BITS-1:0] dvd_q;
  logic [LEN_BITS-1:0] rem_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic                neg_q;
  logic [LEN_BITS:0]   rem_sh;
  logic                ge;

  // Result register
  logic                   out_valid_q;
  logic [CH_BITS-1:0]     out_ch_q;
  logic [SAMPLE_BITS-1:0] out_value_q;
  logic                   out_avg_q;

  logic [PTR_BITS-1:0]           ptr_eff;
  logic [PTR_BITS:0]             ptr_inc;
  logic [ADDR_BITS-1:0]          slot;
  logic signed [SAMPLE_BITS-1:0] ram_rdata;
  logic signed [SAMPLE_BITS-1:0] old_val;
  logic signed [SUM_BITS-1:0]    sum_new;
  logic signed [SUM_BITS-1:0]    sum_sel;
  logic [SUM_BITS-1:0]           quot_s;
  logic                          wl_write;

  // Clamp the written length into 1..WINDOW_MAX
  always_comb begin
    priority if (wl_q == '0) begin
      len = LEN_BITS'(1);
    end else if (wl_q > LEN_BITS'(WINDOW_MAX)) begin
      len = LEN_BITS'(WINDOW_MAX);
    end else begin
      len = wl_q;
    end
  end

  assign wl_write = cfg_we_i && (cfg_index_i == REG_WINDOW_LENGTH);

  assign ptr_eff = ({1'b0, ptr_q[in_ch_q]} >= len) ? '0 : ptr_q[in_ch_q];
  assign ptr_inc = {1'b0, ptr_eff} + (PTR_BITS+1)'(1);
  assign slot    = {in_ch_q, ptr_eff};

  // An entry not yet written since the last clear reads as zero
  assign old_val = full_q[in_ch_q] ? ram_rdata : '0;
  assign sum_new = sum_q[in_ch_q] - SUM_BITS'(old_val) + SUM_BITS'(in_sample_q);
  assign sum_sel = sum_q[in_ch_q];

  assign rem_sh = {rem_q, dvd_q[SUM_BITS-1]};
  assign ge     = (rem_sh >= {1'b0, len});
  assign quot_s = neg_q ? (~dvd_q + SUM_BITS'(1)) : dvd_q;

  mma_ram #(
    .Width(SAMPLE_BITS),
    .Depth(DEPTH)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (cmd_i.update),
    .waddr_i(slot),
    .wdata_i(in_sample_q),
    .re_i   (cmd_i.rd_issue),
    .raddr_i(slot),
    .rdata_o(ram_rdata)
  );

  // Configuration and per-channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q   <= LEN_BITS'(1);
      en_q   <= '1;
      full_q <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        ptr_q[c] <= '0;
        sum_q[c] <= '0;
      end
    end else begin
      if (wl_write) begin
        wl_q   <= cfg_data_i[LEN_BITS-1:0];
        full_q <= '0;
        for (int c = 0; c < CHANNELS; c++) begin
          ptr_q[c] <= '0;
          sum_q[c] <= '0;
        end
      end else if (cmd_i.update) begin
        sum_q[in_ch_q] <= sum_new;
        if (ptr_inc >= len) begin
          ptr_q[in_ch_q]  <= '0;
          full_q[in_ch_q] <= 1'b1;
        end else begin
          ptr_q[in_ch_q] <= ptr_inc[PTR_BITS-1:0];
        end
      end
      if (cfg_we_i && (cfg_index_i == REG_CHANNEL_ENABLE)) begin
        en_q <= cfg_data_i[CHANNELS-1:0];
      end
    end
  end

  // Input capture and divider payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_ch_q     <= s_tdata[CH_BITS-1:0];
      in_sample_q <= s_tdata[CH_BITS +: SAMPLE_BITS];
      in_gauge_q  <= s_tuser[0];
    end
    if (cmd_i.prep) begin
      neg_q <= sum_sel[SUM_BITS-1];
      dvd_q <= sum_sel[SUM_BITS-1] ? (~sum_sel + SUM_BITS'(1)) : sum_sel;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? LEN_BITS'(rem_sh - {1'b0, len}) : rem_sh[LEN_BITS-1:0];
      dvd_q <= {dvd_q[SUM_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.prep) begin
      cnt_q <= CNT_BITS'(SUM_BITS - 1);
    end else if (cmd_i.div_step && (cnt_q != '0)) begin
      cnt_q <= cnt_q - CNT_BITS'(1);
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_ch_q    <= in_ch_q;
      out_avg_q   <= status_o.avg_en;
      out_value_q <= status_o.avg_en ? quot_s[SAMPLE_BITS-1:0] : in_sample_q;
    end
  end

  assign status_o.avg_en   = in_gauge_q && en_q[in_ch_q];
  assign status_o.div_last = (cnt_q == '0);
  assign status_o.out_free = !out_valid_q || m_tready;

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {{(TDATA_BITS - CH_BITS - SAMPLE_BITS){1'b0}}, out_value_q, out_ch_q};
  assign m_tuser  = out_avg_q;

  // Never overwrite a result that is still waiting
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> status_o.out_free)
    else $error("result register overwritten while full");

  // The window update uses read data issued in the previous cycle
  a_read_before_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |-> $past(cmd_i.rd_issue))
    else $error("window update without a preceding read");

  // The divider starts with a full step count
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.prep |=> (cnt_q == CNT_BITS'(SUM_BITS - 1)))
    else $error("divider step count not loaded");

endmodule
